// File: hdl/tag_uid_receive_with_timeouts_defines.svh
// Assertion macros shared by the tag UID receiver modules.
`ifndef TAG_UID_RECEIVE_WITH_TIMEOUTS_DEFINES_SVH
`define TAG_UID_RECEIVE_WITH_TIMEOUTS_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define TUR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tur assertion failed");

// The condition must hold in the cycle after the trigger.
`define TUR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tur assertion failed");

`endif

// File: hdl/tur_pkg.sv
// Shared types and constants of the tag UID receiver.
package tur_pkg;

  localparam int UID_BYTES = 12;
  localparam int UID_IDX_W = (UID_BYTES > 1) ? $clog2(UID_BYTES) : 1;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_MSG   = 2'd2;
  localparam logic [1:0] CMD_DATA  = 2'd3;

  localparam logic [1:0] EV_START  = 2'd0;
  localparam logic [1:0] EV_ACK_TO = 2'd1;
  localparam logic [1:0] EV_UID_TO = 2'd2;
  localparam logic [1:0] EV_DONE   = 2'd3;

  localparam logic REG_ACK_LIMIT = 1'b0;
  localparam logic REG_UID_LIMIT = 1'b1;

  localparam logic [15:0] ACK_LIMIT_RST = 16'd100;
  localparam logic [15:0] UID_LIMIT_RST = 16'd200;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] ack_limit;
    logic [15:0] uid_limit;
  } limits_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [3:0]  count_got;
    logic [31:0] uid_top;
    logic [63:0] uid_rest;
  } res_t;

endpackage

// File: hdl/tur_ifs.sv
// Handshake interfaces for the input, result and configuration channels.
interface tur_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface tur_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [3:0]  count_got;
  logic [31:0] uid_top;
  logic [63:0] uid_rest;
  modport source (output valid, output event_res, output count_got, output uid_top,
                  output uid_rest, input ready);
  modport sink (input valid, input event_res, input count_got, input uid_top,
                input uid_rest, output ready);
endinterface

interface tur_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/tag_uid_receive_with_timeouts.sv
// Top level of the tag UID receiver: input register, limits, core and result queue.
// Accepted words wait in the input register; results leave from the queue head register.
// Throughput: one input word per cycle, as the core updates combinationally on each word;
// input stalls only when both result queue slots are full and the core has a word waiting.
// Reset (synchronous, rst_n low): idle phase, elapsed and byte count zero,
// ack_limit 100, uid_limit 200, all channels empty; the UID byte store is not cleared.
module tag_uid_receive_with_timeouts (
  input  logic clk,
  input  logic rst_n,
  tur_in_if.sink    in_ch,
  tur_out_if.source out_ch,
  tur_cfg_if.sink   cfg_ch
);

  logic             in_valid_r, in_valid_nxt;
  tur_pkg::item_t   item_r;
  tur_pkg::limits_t lim_r, lim_nxt;
  logic             fire;
  logic             accept;
  logic             full;
  logic             push;
  tur_pkg::res_t    push_res;
  tur_pkg::res_t    out_res;

  assign fire        = in_valid_r && !full;
  assign in_ch.ready = !in_valid_r || fire;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    lim_nxt = lim_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tur_pkg::REG_ACK_LIMIT: lim_nxt.ack_limit = cfg_ch.data;
        tur_pkg::REG_UID_LIMIT: lim_nxt.uid_limit = cfg_ch.data;
        default: lim_nxt = lim_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      lim_r.ack_limit <= tur_pkg::ACK_LIMIT_RST;
      lim_r.uid_limit <= tur_pkg::UID_LIMIT_RST;
    end else begin
      in_valid_r <= in_valid_nxt;
      lim_r      <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd       <= in_ch.cmd;
      item_r.data_byte <= in_ch.data_byte;
    end
  end

  tur_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .lim   (lim_r),
    .push  (push),
    .res   (push_res)
  );

  tur_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .full      (full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.event_res = out_res.event_res;
  assign out_ch.count_got = out_res.count_got;
  assign out_ch.uid_top   = out_res.uid_top;
  assign out_ch.uid_rest  = out_res.uid_rest;

endmodule

// File: hdl/tur_core.sv
// Exchange state, timeout counting and UID byte collection for one word per cycle while fire is high.
`include "tag_uid_receive_with_timeouts_defines.svh"

module tur_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  tur_pkg::item_t  item,
  input  tur_pkg::limits_t lim,
  output logic            push,
  output tur_pkg::res_t   res
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ACK  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  store_r [tur_pkg::UID_BYTES];
  logic [7:0]  uid_b [12];
  logic [15:0] el_inc;
  logic [3:0]  cnt_inc;
  logic        store_we;

  assign el_inc  = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign cnt_inc = cnt_r + 4'd1;

  for (genvar i = 0; i < 12; i++) begin : g_uid
    if (i < tur_pkg::UID_BYTES) begin : g_used
      assign uid_b[i] = (cnt_r == 4'(i)) ? item.data_byte : store_r[i];
    end else begin : g_zero
      assign uid_b[i] = 8'd0;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    cnt_nxt     = cnt_r;
    store_we    = 1'b0;
    push        = 1'b0;
    res         = '0;
    if (fire) begin
      case (item.cmd)
        tur_pkg::CMD_TICK: begin
          if (phase_r == PH_ACK) begin
            elapsed_nxt = el_inc;
            if (el_inc > lim.ack_limit) begin
              phase_nxt     = PH_IDLE;
              push          = 1'b1;
              res.event_res = tur_pkg::EV_ACK_TO;
            end
          end else if (phase_r == PH_DATA) begin
            elapsed_nxt = el_inc;
            if (el_inc > lim.uid_limit) begin
              phase_nxt     = PH_IDLE;
              push          = 1'b1;
              res.event_res = tur_pkg::EV_UID_TO;
              res.count_got = cnt_r;
            end
          end
        end
        tur_pkg::CMD_START: begin
          if (phase_r == PH_IDLE) begin
            phase_nxt     = PH_ACK;
            elapsed_nxt   = 16'd0;
            cnt_nxt       = 4'd0;
            push          = 1'b1;
            res.event_res = tur_pkg::EV_START;
          end
        end
        tur_pkg::CMD_MSG: begin
          if (phase_r == PH_ACK) begin
            phase_nxt   = PH_DATA;
            elapsed_nxt = 16'd0;
            cnt_nxt     = 4'd0;
          end
        end
        tur_pkg::CMD_DATA: begin
          if (phase_r == PH_DATA) begin
            store_we = (cnt_r < 4'(tur_pkg::UID_BYTES));
            cnt_nxt  = cnt_inc;
            if (cnt_inc >= 4'(tur_pkg::UID_BYTES)) begin
              phase_nxt     = PH_IDLE;
              push          = 1'b1;
              res.event_res = tur_pkg::EV_DONE;
              res.count_got = cnt_inc;
              res.uid_top   = {uid_b[0], uid_b[1], uid_b[2], uid_b[3]};
              res.uid_rest  = {uid_b[4], uid_b[5], uid_b[6], uid_b[7],
                               uid_b[8], uid_b[9], uid_b[10], uid_b[11]};
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= 16'd0;
      cnt_r     <= 4'd0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[cnt_r[tur_pkg::UID_IDX_W-1:0]] <= item.data_byte;
    end
  end

  `TUR_ASSERT_SAME(a_cnt_range, 1'b1, cnt_r <= 4'(tur_pkg::UID_BYTES))
  `TUR_ASSERT_NEXT(a_done_idle, push && res.event_res == tur_pkg::EV_DONE, phase_r == PH_IDLE)
  `TUR_ASSERT_NEXT(a_start_wait, push && res.event_res == tur_pkg::EV_START,
                   phase_r == PH_ACK && elapsed_r == 16'd0)

endmodule

// File: hdl/tur_outq.sv
// Two-word result queue: an output register with a skid slot behind it.
`include "tag_uid_receive_with_timeouts_defines.svh"

module tur_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tur_pkg::res_t push_res,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output tur_pkg::res_t out_res
);

  logic          v0_r, v0_nxt;
  logic          v1_r, v1_nxt;
  tur_pkg::res_t head_r, head_nxt;
  tur_pkg::res_t skid_r, skid_nxt;
  logic          pop;

  assign pop       = v0_r && out_ready;
  assign full      = v1_r;
  assign out_valid = v0_r;
  assign out_res   = head_r;

  always_comb begin
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (pop) begin
      if (v1_r) begin
        head_nxt = skid_r;
        v1_nxt   = push;
        skid_nxt = push ? push_res : skid_r;
      end else begin
        head_nxt = push_res;
        v0_nxt   = push;
      end
    end else if (push) begin
      if (!v0_r) begin
        head_nxt = push_res;
        v0_nxt   = 1'b1;
      end else begin
        skid_nxt = push_res;
        v1_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  `TUR_ASSERT_SAME(a_q_order, v1_r, v0_r)
  `TUR_ASSERT_SAME(a_q_no_overflow, push, !v1_r)
  `TUR_ASSERT_NEXT(a_q_fill, push && !pop, v0_r)

endmodule
